// ----- rtl/nnvs_pkg.sv -----
// Shared types and constants for the nearest-neighbour vehicle selector.
`default_nettype none
package nnvs_pkg;

   // Field widths
   localparam int COORD_W     = 24;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int DIST_W      = 26;
   localparam int ID_W        = 8;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int REGIONS     = 3;

   // Queue depths
   localparam int ITEM_QUEUE_DEPTH   = 4;
   localparam int RESULT_QUEUE_DEPTH = 2;

   // Region slots
   localparam int REGION_FRONT = 0;
   localparam int REGION_RIGHT = 1;
   localparam int REGION_LEFT  = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_NEAR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_FAR    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LANE_HALF    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADJACENT_FAR = 3'd3;

   // Register reset values, centimeters
   localparam logic [CFG_W-1:0] FRONT_NEAR_RESET   = 16'd400;
   localparam logic [CFG_W-1:0] FRONT_FAR_RESET    = 16'd1500;
   localparam logic [CFG_W-1:0] LANE_HALF_RESET    = 16'd175;
   localparam logic [CFG_W-1:0] ADJACENT_FAR_RESET = 16'd530;

   // Classified vehicle handed from front to back
   typedef struct packed {
      logic [DIST_W-1:0]  mdist;
      logic [ID_W-1:0]    id;
      logic [REGIONS-1:0] hit;
      logic               last;
   } item_type;

   // One query result
   typedef struct packed {
      logic [ID_W-1:0] front_id;
      logic            front_found;
      logic [ID_W-1:0] right_id;
      logic            right_found;
      logic [ID_W-1:0] left_id;
      logic            left_found;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/nnvs_fifo.sv -----
// Small first-in first-out queue of registers.
`default_nettype none
module nnvs_fifo
   import nnvs_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/nnvs_front.sv -----
// Front end: accepts vehicle beats, holds the region bounds, classifies.
`default_nettype none
module nnvs_front
   import nnvs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // vehicle input
   input  wire logic                   push,
   output logic                        full,
   input  wire logic signed [COORD_W-1:0] ego_x,
   input  wire logic signed [COORD_W-1:0] ego_y,
   input  wire logic signed [COORD_W-1:0] veh_x,
   input  wire logic signed [COORD_W-1:0] veh_y,
   input  wire logic [ID_W-1:0]        veh_id,
   input  wire logic                   in_lane,
   input  wire logic                   last,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata,
   // item queue
   output logic                        q_push,
   output item_type                    q_item,
   input  wire logic                   q_full
);

   logic [CFG_W-1:0] front_near_ff, front_far_ff, lane_half_ff, adjacent_far_ff;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic [ID_W-1:0]          id_ff;
   logic                     in_lane_ff, last_ff;

   logic                     accept, advance, keep;
   logic [DIFF_W-1:0]        adx, ady;
   logic signed [DIFF_W-1:0] near_s, far_s, lh_s, af_s, lh_neg, af_neg;
   logic                     front_hit, right_hit, left_hit;

   // Register file, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_near_ff   <= FRONT_NEAR_RESET;
         front_far_ff    <= FRONT_FAR_RESET;
         lane_half_ff    <= LANE_HALF_RESET;
         adjacent_far_ff <= ADJACENT_FAR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRONT_NEAR:   front_near_ff   <= csr_wdata;
            CSR_FRONT_FAR:    front_far_ff    <= csr_wdata;
            CSR_LANE_HALF:    lane_half_ff    <= csr_wdata;
            CSR_ADJACENT_FAR: adjacent_far_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: offsets to the ego vehicle
   assign advance     = s1_valid_ff && !q_full;
   assign full        = s1_valid_ff && q_full;
   assign accept      = push && !full;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff      <= DIFF_W'(veh_x) - DIFF_W'(ego_x);
         dy_ff      <= DIFF_W'(veh_y) - DIFF_W'(ego_y);
         id_ff      <= veh_id;
         in_lane_ff <= in_lane;
         last_ff    <= last;
      end
   end

   // Classification against the region bounds
   assign near_s = $signed({{(DIFF_W-CFG_W){1'b0}}, front_near_ff});
   assign far_s  = $signed({{(DIFF_W-CFG_W){1'b0}}, front_far_ff});
   assign lh_s   = $signed({{(DIFF_W-CFG_W){1'b0}}, lane_half_ff});
   assign af_s   = $signed({{(DIFF_W-CFG_W){1'b0}}, adjacent_far_ff});
   assign lh_neg = -lh_s;
   assign af_neg = -af_s;

   assign adx = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign ady = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);

   assign front_hit = in_lane_ff && (dx_ff > near_s) && (dx_ff < far_s)
                      && (dy_ff > lh_neg) && (dy_ff < lh_s);
   assign right_hit = in_lane_ff && (dy_ff > af_neg) && (dy_ff < lh_neg);
   assign left_hit  = in_lane_ff && (dy_ff > lh_s) && (dy_ff < af_s);

   always_comb begin
      q_item                    = '0;
      q_item.mdist              = DIST_W'(adx) + DIST_W'(ady);
      q_item.id                 = id_ff;
      q_item.hit[REGION_FRONT]  = front_hit;
      q_item.hit[REGION_RIGHT]  = right_hit;
      q_item.hit[REGION_LEFT]   = left_hit;
      q_item.last               = last_ff;
   end

   // Beats that touch no region and close no query are dropped here
   assign keep   = front_hit || right_hit || left_hit || last_ff;
   assign q_push = advance && keep;

endmodule
`default_nettype wire

// ----- rtl/nnvs_back.sv -----
// Back end: running minimum per region and result build on the last beat.
`default_nettype none
module nnvs_back
   import nnvs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   // item queue
   input  wire item_type q_item,
   input  wire logic     q_empty,
   output logic          q_pop,
   // result queue
   output logic          r_push,
   output result_type    r_result,
   input  wire logic     r_full
);

   logic [DIST_W-1:0]  best_dist_ff [REGIONS];
   logic [DIST_W-1:0]  best_dist_in [REGIONS];
   logic [ID_W-1:0]    best_id_ff   [REGIONS];
   logic [ID_W-1:0]    best_id_in   [REGIONS];
   logic [REGIONS-1:0] found_ff, found_in;
   logic [REGIONS-1:0] take;

   // A closing beat waits for room in the result queue
   assign q_pop  = !q_empty && (!q_item.last || !r_full);
   assign r_push = q_pop && q_item.last;

   // Strictly smaller distance replaces, so the first of equals stays
   always_comb begin
      for (int r = 0; r < REGIONS; r++) begin
         take[r] = q_item.hit[r] && (!found_ff[r] || (q_item.mdist < best_dist_ff[r]));
         best_dist_in[r] = take[r] ? q_item.mdist : best_dist_ff[r];
         best_id_in[r]   = take[r] ? q_item.id : best_id_ff[r];
         found_in[r]     = found_ff[r] || take[r];
      end
   end

   // Result from the updated state
   always_comb begin
      r_result             = '0;
      r_result.front_found = found_in[REGION_FRONT];
      r_result.front_id    = found_in[REGION_FRONT] ? best_id_in[REGION_FRONT] : '0;
      r_result.right_found = found_in[REGION_RIGHT];
      r_result.right_id    = found_in[REGION_RIGHT] ? best_id_in[REGION_RIGHT] : '0;
      r_result.left_found  = found_in[REGION_LEFT];
      r_result.left_id     = found_in[REGION_LEFT] ? best_id_in[REGION_LEFT] : '0;
   end

   // Found flags: cleared at reset and after each query
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
      end else if (q_pop) begin
         found_ff <= q_item.last ? '0 : found_in;
      end
   end

   // Best entries only matter while their found flag is set
   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int r = 0; r < REGIONS; r++) begin
            best_dist_ff[r] <= best_dist_in[r];
            best_id_ff[r]   <= best_id_in[r];
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/nearest_neighbour_vehicle_select.sv -----
// Top level of the nearest-neighbour vehicle selector.
//
// Vehicle beats enter on push/full: ego and vehicle position, id, in_lane
// flag and a last marker that closes the query. For each in-lane vehicle
// the front end forms its offset to the ego and tests the front, right and
// left regions; the back end keeps the nearest vehicle (Manhattan distance,
// first one wins ties) per region. The last beat of a query produces one
// result on empty/pop with three ids and found flags, then clears.
// Region bounds are written on the csr_ port, which is always ready; write
// them only while no query is in flight.
// A result passes the input stage, item queue and result queue.
// Throughput: one beat per cycle while full is low, set by the classify
// stage and the minimum update in the back end.
// When the result side is not popped, up to RESULT_DEPTH results wait;
// the back end then holds the next closing beat at the head of the item
// queue, the beats behind it fill the queue and the input stage, and full
// rises.
// Reset (synchronous) clears both queues and the running state and loads
// the default bounds; no clearing pass is needed.
`default_nettype none
module nearest_neighbour_vehicle_select
   import nnvs_pkg::*;
#(
   parameter int ITEM_DEPTH   = ITEM_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = RESULT_QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // vehicle input
   input  wire logic                      push,
   output logic                           full,
   input  wire logic signed [COORD_W-1:0] req_ego_x,
   input  wire logic signed [COORD_W-1:0] req_ego_y,
   input  wire logic signed [COORD_W-1:0] req_veh_x,
   input  wire logic signed [COORD_W-1:0] req_veh_y,
   input  wire logic [ID_W-1:0]           req_veh_id,
   input  wire logic                      req_in_lane,
   input  wire logic                      req_last,
   // results
   output logic                           empty,
   input  wire logic                      pop,
   output logic [ID_W-1:0]                rsp_front_id,
   output logic                           rsp_front_found,
   output logic [ID_W-1:0]                rsp_right_id,
   output logic                           rsp_right_found,
   output logic [ID_W-1:0]                rsp_left_id,
   output logic                           rsp_left_found,
   // register writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CFG_W-1:0]          csr_wdata
);

   logic       q_push, q_full, q_pop, q_empty;
   item_type   q_wdata, q_rdata;
   logic       r_push, r_full;
   result_type r_wdata, r_rdata;

   nnvs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .ego_x     (req_ego_x),
      .ego_y     (req_ego_y),
      .veh_x     (req_veh_x),
      .veh_y     (req_veh_y),
      .veh_id    (req_veh_id),
      .in_lane   (req_in_lane),
      .last      (req_last),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_item    (q_wdata),
      .q_full    (q_full)
   );

   nnvs_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (ITEM_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   nnvs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_rdata),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .r_push   (r_push),
      .r_result (r_wdata),
      .r_full   (r_full)
   );

   nnvs_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (r_push),
      .wdata (r_wdata),
      .full  (r_full),
      .pop   (pop),
      .rdata (r_rdata),
      .empty (empty)
   );

   assign rsp_front_id    = r_rdata.front_id;
   assign rsp_front_found = r_rdata.front_found;
   assign rsp_right_id    = r_rdata.right_id;
   assign rsp_right_found = r_rdata.right_found;
   assign rsp_left_id     = r_rdata.left_id;
   assign rsp_left_found  = r_rdata.left_found;

endmodule
`default_nettype wire

// ----- rtl/nnvs_checker.sv -----
// Port-level checker for the nearest-neighbour vehicle selector, with bind.
`default_nettype none
module nnvs_port_checks
   import nnvs_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      push,
   input wire logic                      full,
   input wire logic                      req_last,
   input wire logic                      empty,
   input wire logic                      pop,
   input wire logic [ID_W-1:0]           rsp_front_id,
   input wire logic                      rsp_front_found,
   input wire logic [ID_W-1:0]           rsp_right_id,
   input wire logic                      rsp_right_found,
   input wire logic [ID_W-1:0]           rsp_left_id,
   input wire logic                      rsp_left_found
);

   logic       close_beat, result_beat;
   logic [7:0] open_ff, open_in;

   // Closing beats taken whose result has not been popped yet
   assign close_beat  = push && !full && req_last;
   assign result_beat = pop && !empty;

   always_comb begin
      open_in = open_ff;
      if (close_beat && !result_beat) begin
         open_in = open_ff + 1'b1;
      end else if (result_beat && !close_beat) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // Reset leaves no result pending and room for input
   a_reset_idle: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (empty && !full))
      else $error("result or full flag present right after reset");

   // A missing vehicle reads as id zero
   a_front_masked: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_front_found) |-> (rsp_front_id == '0))
      else $error("front id nonzero without front_found");

   a_side_masked: assert property (@(posedge clock) disable iff (reset)
      (!empty && ((!rsp_right_found && rsp_right_id != '0) ||
                  (!rsp_left_found && rsp_left_id != '0))) |-> 1'b0)
      else $error("side id nonzero without its found flag");

   // A result on the ports needs a closing beat that has not been answered
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (open_ff != '0))
      else $error("result appeared without a closing beat");

   // A waiting result holds until popped
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_front_id) && $stable(rsp_right_id)
                            && $stable(rsp_left_id) && $stable(rsp_front_found)
                            && $stable(rsp_right_found) && $stable(rsp_left_found)))
      else $error("waiting result changed before pop");

endmodule

bind nearest_neighbour_vehicle_select nnvs_port_checks u_nnvs_port_checks (.*);
`default_nettype wire

// ----- bench/nnvs_checker.sv -----
`timescale 1ns / 100ps
// Watches the vehicle, result and register channels, predicts each selection and compares it.
module nnvs_checker
   import nnvs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic                      full,
   input  wire logic signed [COORD_W-1:0] req_ego_x,
   input  wire logic signed [COORD_W-1:0] req_ego_y,
   input  wire logic signed [COORD_W-1:0] req_veh_x,
   input  wire logic signed [COORD_W-1:0] req_veh_y,
   input  wire logic [ID_W-1:0]           req_veh_id,
   input  wire logic                      req_in_lane,
   input  wire logic                      req_last,
   input  wire logic                      empty,
   input  wire logic                      pop,
   input  wire logic [ID_W-1:0]           rsp_front_id,
   input  wire logic                      rsp_front_found,
   input  wire logic [ID_W-1:0]           rsp_right_id,
   input  wire logic                      rsp_right_found,
   input  wire logic [ID_W-1:0]           rsp_left_id,
   input  wire logic                      rsp_left_found,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CFG_W-1:0]          csr_wdata,
   output int                             mismatches,
   output int                             outstanding,
   output int                             selections_checked
);

   // Bounds as the block should hold them
   logic [CFG_W-1:0] front_near;
   logic [CFG_W-1:0] front_far;
   logic [CFG_W-1:0] lane_half;
   logic [CFG_W-1:0] adjacent_far;

   // Running nearest vehicle per region
   logic [DIST_W-1:0] nearest_dist [REGIONS];
   logic [ID_W-1:0]   nearest_id   [REGIONS];
   logic              nearest_seen [REGIONS];

   result_type selections_due [$];
   result_type due;
   int         mismatch_count = 0;
   int         checked_count  = 0;

   function automatic void clear_nearest();
      for (int r = 0; r < REGIONS; r++) begin
         nearest_dist[r] = '1;
         nearest_id[r]   = '0;
         nearest_seen[r] = 1'b0;
      end
   endfunction

   // Strictly closer replaces, so the first of equal distances stays
   function automatic void offer_vehicle(int r, logic [DIST_W-1:0] mdist, logic [ID_W-1:0] id);
      if (!nearest_seen[r] || mdist < nearest_dist[r]) begin
         nearest_dist[r] = mdist;
         nearest_id[r]   = id;
         nearest_seen[r] = 1'b1;
      end
   endfunction

   // Classify one vehicle beat; a closing beat queues the selection
   function automatic void select_nearest(logic signed [COORD_W-1:0] ego_x,
                                          logic signed [COORD_W-1:0] ego_y,
                                          logic signed [COORD_W-1:0] veh_x,
                                          logic signed [COORD_W-1:0] veh_y,
                                          logic [ID_W-1:0] id, logic in_lane,
                                          logic closing);
      longint            dx, dy, adx, ady, fnear, ffar, lh, af;
      logic [DIST_W-1:0] mdist;
      result_type        sel;
      dx    = longint'(veh_x) - longint'(ego_x);
      dy    = longint'(veh_y) - longint'(ego_y);
      adx   = dx < 0 ? -dx : dx;
      ady   = dy < 0 ? -dy : dy;
      mdist = DIST_W'(adx + ady);
      fnear = longint'(front_near);
      ffar  = longint'(front_far);
      lh    = longint'(lane_half);
      af    = longint'(adjacent_far);
      if (in_lane) begin
         if (dx > fnear && dx < ffar && dy > -lh && dy < lh)
            offer_vehicle(REGION_FRONT, mdist, id);
         if (dy > -af && dy < -lh)
            offer_vehicle(REGION_RIGHT, mdist, id);
         if (dy > lh && dy < af)
            offer_vehicle(REGION_LEFT, mdist, id);
      end
      if (closing) begin
         sel.front_id    = nearest_seen[REGION_FRONT] ? nearest_id[REGION_FRONT] : '0;
         sel.front_found = nearest_seen[REGION_FRONT];
         sel.right_id    = nearest_seen[REGION_RIGHT] ? nearest_id[REGION_RIGHT] : '0;
         sel.right_found = nearest_seen[REGION_RIGHT];
         sel.left_id     = nearest_seen[REGION_LEFT] ? nearest_id[REGION_LEFT] : '0;
         sel.left_found  = nearest_seen[REGION_LEFT];
         selections_due  = {selections_due, sel};
         clear_nearest();
      end
   endfunction

   function automatic void check_field(string field, logic [ID_W-1:0] want,
                                       logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         selections_due.delete();
         clear_nearest();
         front_near   = FRONT_NEAR_RESET;
         front_far    = FRONT_FAR_RESET;
         lane_half    = LANE_HALF_RESET;
         adjacent_far = ADJACENT_FAR_RESET;
      end else begin
         // Result beat against the oldest selection due
         if (pop && !empty) begin
            if (selections_due.size() == 0) begin
               $error("unexpected result: front %0d/%0b right %0d/%0b left %0d/%0b",
                      rsp_front_id, rsp_front_found, rsp_right_id, rsp_right_found,
                      rsp_left_id, rsp_left_found);
               mismatch_count++;
            end else begin
               due = selections_due.pop_front();
               check_field("front_id", due.front_id, rsp_front_id);
               check_field("front_found", ID_W'(due.front_found), ID_W'(rsp_front_found));
               check_field("right_id", due.right_id, rsp_right_id);
               check_field("right_found", ID_W'(due.right_found), ID_W'(rsp_right_found));
               check_field("left_id", due.left_id, rsp_left_id);
               check_field("left_found", ID_W'(due.left_found), ID_W'(rsp_left_found));
               checked_count++;
            end
         end
         if (push && !full)
            select_nearest(req_ego_x, req_ego_y, req_veh_x, req_veh_y, req_veh_id,
                           req_in_lane, req_last);
         // A bound write applies from the next beat on
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRONT_NEAR:   front_near   = csr_wdata;
               CSR_FRONT_FAR:    front_far    = csr_wdata;
               CSR_LANE_HALF:    lane_half    = csr_wdata;
               CSR_ADJACENT_FAR: adjacent_far = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches         <= mismatch_count;
      outstanding        <= selections_due.size();
      selections_checked <= checked_count;
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Stimulus, pressure phases and verdict for the nearest-neighbour vehicle selector.
module tb;
   import nnvs_pkg::*;

   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     IDLE_PERCENT  = 14;
   localparam int     PHASE_BEATS   = 225;
   localparam longint COORD_MIN     = -8388608;
   localparam longint COORD_MAX     = 8388607;
   localparam longint EGO_MARGIN    = 100000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd6;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic signed [COORD_W-1:0] req_ego_x = '0;
   logic signed [COORD_W-1:0] req_ego_y = '0;
   logic signed [COORD_W-1:0] req_veh_x = '0;
   logic signed [COORD_W-1:0] req_veh_y = '0;
   logic [ID_W-1:0]           req_veh_id = '0;
   logic                      req_in_lane = 1'b0;
   logic                      req_last = 1'b0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [ID_W-1:0]           rsp_front_id;
   logic                      rsp_front_found;
   logic [ID_W-1:0]           rsp_right_id;
   logic                      rsp_right_found;
   logic [ID_W-1:0]           rsp_left_id;
   logic                      rsp_left_found;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]          csr_wdata = '0;
   int                        mismatches;
   int                        outstanding;
   int                        selections_checked;

   // Run bookkeeping and receiver control
   bit     calm = 1'b0;
   int     hold_token = 0;
   int     hold_seen = 0;
   int     hold_left = 0;
   int     cycle_count = 0;
   int     beats_sent = 0;
   int     queries_sent = 0;
   int     settings_used = 0;
   int     stall_cycles = 0;
   longint prev_dx = 0;
   longint prev_dy = 0;

   // Bounds currently programmed, used to aim offsets at region edges
   longint front_near_set   = FRONT_NEAR_RESET;
   longint front_far_set    = FRONT_FAR_RESET;
   longint lane_half_set    = LANE_HALF_RESET;
   longint adjacent_far_set = ADJACENT_FAR_RESET;

   nearest_neighbour_vehicle_select DUT (.*);
   nnvs_checker selection_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random pop gaps, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop       <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         pop       <= 1'b0;
      end else begin
         pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb NOT OK");
      $finish;
   end

   // One vehicle beat, held until taken
   task automatic send_vehicle(input longint ego_x, ego_y, veh_x, veh_y,
                               input logic [ID_W-1:0] id, input bit in_lane, closing);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_ego_x   <= COORD_W'(ego_x);
      req_ego_y   <= COORD_W'(ego_y);
      req_veh_x   <= COORD_W'(veh_x);
      req_veh_y   <= COORD_W'(veh_y);
      req_veh_id  <= id;
      req_in_lane <= in_lane;
      req_last    <= closing;
      @(posedge clock);
      while (full) begin
         stall_cycles++;
         @(posedge clock);
      end
      beats_sent++;
      if (closing)
         queries_sent++;
   endtask

   // Vehicle at a given offset from a random ego position
   task automatic send_offset(input longint dx, dy, input logic [ID_W-1:0] id,
                              input bit in_lane, closing);
      longint ex, ey;
      ex = longint'($urandom_range(32'(2 * (COORD_MAX - EGO_MARGIN)))) - (COORD_MAX - EGO_MARGIN);
      ey = longint'($urandom_range(32'(2 * (COORD_MAX - EGO_MARGIN)))) - (COORD_MAX - EGO_MARGIN);
      send_vehicle(ex, ey, ex + dx, ey + dy, id, in_lane, closing);
   endtask

   // Offset on a bound edge, on a coarse grid (ties) or uniform
   function automatic longint pick_offset(longint edge_a, edge_b, span);
      longint v;
      int     r;
      r = $urandom_range(99);
      if (r < 25) begin
         case ($urandom_range(3))
            0: v = edge_a;
            1: v = -edge_a;
            2: v = edge_b;
            default: v = -edge_b;
         endcase
         v = v + longint'($urandom_range(2)) - 1;
      end else if (r < 45) begin
         v = 50 * (longint'($urandom_range(32'(2 * (span / 50)))) - span / 50);
      end else begin
         v = longint'($urandom_range(32'(2 * span))) - span;
      end
      return v;
   endfunction

   task automatic send_random_vehicle(input bit closing);
      longint dx, dy;
      int     r;
      r = $urandom_range(99);
      if (r < 5) begin
         // noise anywhere in the coordinate space
         send_vehicle(longint'($urandom), longint'($urandom), longint'($urandom),
                      longint'($urandom), ID_W'($urandom), 1'($urandom_range(1)), closing);
      end else begin
         if (r < 13) begin
            // same offset again: an exact distance tie
            dx = prev_dx;
            dy = prev_dy;
         end else begin
            dx = pick_offset(front_near_set, front_far_set, front_far_set + 300);
            dy = pick_offset(lane_half_set, adjacent_far_set, adjacent_far_set + 300);
         end
         prev_dx = dx;
         prev_dy = dy;
         send_offset(dx, dy, ID_W'($urandom), $urandom_range(99) >= 12, closing);
      end
   endtask

   // Whole queries of mostly short length until the beat budget is spent
   task automatic run_queries(input int budget);
      int sent, len, r;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(99);
         if (r < 10)
            len = 1;
         else if (r < 75)
            len = $urandom_range(6, 2);
         else if (r < 95)
            len = $urandom_range(20, 7);
         else
            len = $urandom_range(60, 21);
         for (int k = 0; k < len; k++)
            send_random_vehicle(k == len - 1);
         sent += len;
      end
   endtask

   // Stop sending and wait for every selection due, then let the pipe empty
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_bounds(input longint fnear, ffar, lh, af);
      drain();
      write_csr(CSR_FRONT_NEAR, CFG_W'(fnear));
      write_csr(CSR_FRONT_FAR, CFG_W'(ffar));
      write_csr(CSR_LANE_HALF, CFG_W'(lh));
      write_csr(CSR_ADJACENT_FAR, CFG_W'(af));
      csr_valid        <= 1'b0;
      front_near_set   = fnear;
      front_far_set    = ffar;
      lane_half_set    = lh;
      adjacent_far_set = af;
      settings_used++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // A write to an unmapped index must leave the defaults alone
      write_csr(CSR_UNUSED_INDEX, 16'hFFFF);
      csr_valid <= 1'b0;

      // Directed, default bounds: nothing found at all
      send_offset(1000, 0, 8'd1, 1'b0, 1'b1);
      // Ties, exact bounds, out-of-lane vehicle, closing beat that wins
      send_offset(1000, 0, 8'd255, 1'b1, 1'b0);
      send_offset(900, 100, 8'd7, 1'b1, 1'b0);
      send_offset(400, 0, 8'd3, 1'b1, 1'b0);
      send_offset(1500, 0, 8'd4, 1'b1, 1'b0);
      send_offset(600, 175, 8'd5, 1'b1, 1'b0);
      send_offset(600, -530, 8'd6, 1'b1, 1'b0);
      send_offset(-5000, -176, 8'd0, 1'b1, 1'b0);
      send_offset(401, 174, 8'd10, 1'b1, 1'b0);
      send_offset(401, -174, 8'd11, 1'b1, 1'b0);
      send_offset(500, 0, 8'd12, 1'b0, 1'b0);
      send_offset(0, 529, 8'd128, 1'b1, 1'b0);
      send_offset(0, 176, 8'd200, 1'b1, 1'b1);
      // Coordinate extremes
      send_vehicle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 8'd255, 1'b1, 1'b1);
      send_vehicle(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 8'd0, 1'b1, 1'b1);
      send_vehicle(COORD_MAX - 1000, COORD_MIN, COORD_MAX, COORD_MIN, 8'd77, 1'b1, 1'b0);
      send_vehicle(COORD_MIN, COORD_MIN + 300, COORD_MIN + 20, COORD_MIN, 8'd99, 1'b1, 1'b1);

      // Random phases over several bound settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_bounds(FRONT_NEAR_RESET, FRONT_FAR_RESET, LANE_HALF_RESET,
                          ADJACENT_FAR_RESET);
            1: set_bounds(0, 0, 0, 0);
            2: set_bounds(65535, 65535, 65535, 65535);
            3: set_bounds(0, 65535, 300, 65535);
            4: set_bounds(1500, 400, 530, 175);
            5: set_bounds(0, 3, 1, 3);
            default: set_bounds(longint'($urandom_range(2000)), longint'($urandom_range(4000)),
                                longint'($urandom_range(400)), longint'($urandom_range(1200)));
         endcase
         // one phase with no idling on either side
         calm <= (p == 6);
         run_queries(PHASE_BEATS);
      end

      // Receiver holds off while beats keep coming, so the input stalls
      set_bounds(FRONT_NEAR_RESET, FRONT_FAR_RESET, LANE_HALF_RESET, ADJACENT_FAR_RESET);
      calm       <= 1'b0;
      hold_token <= hold_token + 1;
      run_queries(60);

      drain();
      $display("tb: %0d vehicle beats in %0d queries over %0d bound settings",
               beats_sent, queries_sent, settings_used);
      $display("tb: %0d selections checked, input stalled %0d cycles",
               selections_checked, stall_cycles);
      if (mismatches == 0 && outstanding == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/nnvs_pkg.sv
rtl/nnvs_fifo.sv
rtl/nnvs_front.sv
rtl/nnvs_back.sv
rtl/nearest_neighbour_vehicle_select.sv
rtl/nnvs_checker.sv
bench/nnvs_checker.sv
bench/tb.sv
